// ----- hw/rtl/tlv_packet_skeleton_parser_unit_assert.svh -----
// Assertion macros shared by the checker of the packet skeleton parser.
`ifndef TLV_PACKET_SKELETON_PARSER_UNIT_ASSERT_SVH
`define TLV_PACKET_SKELETON_PARSER_UNIT_ASSERT_SVH

// Implication that is checked only outside reset.
`define TLVPSP_ASSERT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is checked during reset as well.
`define TLVPSP_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/tlvpsp_pkg.sv -----
// Types and constants of the packet skeleton parser.
`timescale 1ns / 1ps
package tlvpsp_pkg;

   // Field kinds reported on the result stream.
   localparam logic [3:0] KIND_HOPLIMIT  = 4'd0;
   localparam logic [3:0] KIND_CPI       = 4'd8;
   localparam logic [3:0] KIND_FRAG      = 4'd9;
   localparam logic [3:0] KIND_NAME      = 4'd4;
   localparam logic [3:0] KIND_KEYID     = 4'd5;
   localparam logic [3:0] KIND_OBJHASH   = 4'd6;
   localparam logic [3:0] KIND_EXPIRY    = 4'd7;
   localparam logic [3:0] KIND_CERT      = 4'd10;
   localparam logic [3:0] KIND_PUBKEY    = 4'd11;
   localparam logic [3:0] KIND_DONE      = 4'd12;

   // Packet types accepted in the fixed header.
   localparam logic [7:0] PKT_INTEREST   = 8'h00;
   localparam logic [7:0] PKT_OBJECT     = 8'h01;
   localparam logic [7:0] PKT_RETURN     = 8'h02;
   localparam logic [7:0] PKT_CONTROL    = 8'h04;
   localparam logic [7:0] PKT_HOPHASH    = 8'hA4;

   // TLV type codes.
   localparam logic [15:0] MSG_INTEREST  = 16'h0001;
   localparam logic [15:0] MSG_OBJECT    = 16'h0002;
   localparam logic [15:0] MSG_MANIFEST  = 16'h0006;
   localparam logic [15:0] T_CPI         = 16'hBEEF;
   localparam logic [15:0] T_FRAG        = 16'h0005;
   localparam logic [15:0] T_NAME        = 16'h0000;
   localparam logic [15:0] T_KEYID       = 16'h0002;
   localparam logic [15:0] T_OBJHASH     = 16'h0003;
   localparam logic [15:0] T_EXPIRY      = 16'h0006;
   localparam logic [15:0] ALG_CONTAINER = 16'h0003;
   localparam logic [15:0] T_VT_LO       = 16'h0006;
   localparam logic [15:0] T_VT_HI       = 16'h0008;
   localparam logic [15:0] T_SIG_KEYID   = 16'h0009;
   localparam logic [15:0] T_SIG_CERT    = 16'h000C;
   localparam logic [15:0] T_SIG_PUBKEY  = 16'h000B;

   // One result record.
   typedef struct packed {
      logic        last;
      logic        ok;
      logic [15:0] length;
      logic [15:0] offset;
      logic [3:0]  kind;
   } rec_type;

   // Results caused by one accepted byte: a field record and a done record.
   typedef struct packed {
      logic    fld_valid;
      rec_type fld;
      logic    done_valid;
      rec_type done;
   } push_type;

endpackage

// ----- hw/rtl/tlvpsp_core.sv -----
// Parse state and per-byte parsing logic of the packet skeleton parser.
`timescale 1ns / 1ps
module tlvpsp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   output tlvpsp_pkg::push_type push
);
   import tlvpsp_pkg::*;

   typedef enum logic [3:0] {
      PH_FIX, PH_PERHOP, PH_MSG, PH_BODYI, PH_BODYO,
      PH_VALALG, PH_VALTYPE, PH_SIG, PH_IDLE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  hend_ff, hend_in;
   logic [15:0] pend_ff, pend_in;
   logic [31:0] tl_ff, tl_in;
   logic [16:0] se0_ff, se0_in, se1_ff, se1_in, se2_ff, se2_in;
   logic [16:0] start_ff, start_in;
   logic [1:0]  fc_ff, fc_in;
   logic        good_ff, good_in;

   logic [17:0] s18, p18, v18, e18;
   logic [15:0] ttype, tlen;
   logic [1:0]  lim;
   logic        put;
   logic [3:0]  put_kind;

   // Next parse state and the results of the byte.
   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; kind_in = kind_ff; hend_in = hend_ff;
      pend_in = pend_ff; tl_in = tl_ff; se0_in = se0_ff; se1_in = se1_ff;
      se2_in = se2_ff; start_in = start_ff; fc_in = fc_ff; good_in = good_ff;
      put = 1'b0; put_kind = KIND_HOPLIMIT;
      s18 = 18'd0; v18 = 18'd0; e18 = 18'd0; lim = 2'd0;
      ttype = 16'd0; tlen = 16'd0;
      p18 = {2'b00, pos_ff};
      push = '0;

      if (phase_ff == PH_FIX) begin
         case (pos_ff)
            16'd0: tl_in = {24'd0, data_byte};
            16'd1: kind_in = data_byte;
            16'd2: pend_in = {data_byte, 8'd0};
            16'd3: pend_in = {pend_ff[15:8], data_byte};
            16'd7: begin
               hend_in = data_byte;
               if (tl_ff == 32'd1 && (kind_ff == PKT_INTEREST || kind_ff == PKT_OBJECT ||
                   kind_ff == PKT_RETURN || kind_ff == PKT_CONTROL ||
                   kind_ff == PKT_HOPHASH) && data_byte >= 8'd8 &&
                   pend_ff >= {8'd0, data_byte}) begin
                  good_in = 1'b1;
                  if (kind_ff == PKT_INTEREST) begin
                     push.fld_valid = 1'b1;
                     push.fld.kind = KIND_HOPLIMIT;
                     push.fld.offset = 16'd4;
                     push.fld.length = 16'd1;
                     push.fld.ok = 1'b1;
                  end
                  phase_in = PH_PERHOP;
                  start_in = 17'd8;
               end else begin
                  phase_in = PH_IDLE;
               end
               tl_in = 32'd0;
            end
            default: ;
         endcase
      end else begin
         // Skip areas whose next header cannot start.
         if (phase_in == PH_PERHOP && !({1'b0, start_in} + 18'd4 < {10'd0, hend_ff})) begin
            phase_in = PH_MSG;
            start_in = {9'd0, hend_ff};
         end
         lim = (phase_in == PH_BODYI) ? 2'd3 : 2'd2;
         if ((phase_in == PH_BODYI || phase_in == PH_BODYO) &&
             !(p18 < {1'b0, se0_ff} && start_in < se0_ff && fc_ff < lim)) begin
            phase_in = PH_VALALG;
            start_in = se0_ff;
         end
         s18 = {1'b0, start_in};
         if ((phase_in == PH_MSG || phase_in == PH_VALALG) &&
             !(s18 + 18'd4 < {2'b00, pend_ff}))
            phase_in = PH_IDLE;
         if (phase_in == PH_VALTYPE && !(s18 + 18'd4 < {1'b0, se1_ff}))
            phase_in = PH_IDLE;
         if (phase_in == PH_SIG && !(s18 + 18'd4 < {1'b0, se2_ff}))
            phase_in = PH_IDLE;

         // Capture the four type-length bytes, then act on the header.
         if (phase_in != PH_IDLE && p18 >= s18 && p18 <= s18 + 18'd3) begin
            tl_in = {tl_ff[23:0], data_byte};
            if (p18 == s18 + 18'd3) begin
               ttype = tl_in[31:16];
               tlen = tl_in[15:0];
               v18 = s18 + 18'd4;
               e18 = v18 + {2'b00, tlen};
               case (phase_in)
                  PH_PERHOP: begin
                     if (e18 <= {10'd0, hend_ff} && ttype >= 16'd1 && ttype <= 16'd3) begin
                        put = 1'b1; put_kind = ttype[3:0];
                     end
                     start_in = e18[16:0];
                  end
                  PH_MSG: begin
                     if (e18 > {2'b00, pend_ff}) begin
                        phase_in = PH_IDLE;
                     end else begin
                        se0_in = e18[16:0];
                        fc_in = 2'd0;
                        if (ttype == MSG_INTEREST) begin
                           phase_in = PH_BODYI; start_in = v18[16:0];
                        end else if (ttype == MSG_OBJECT || ttype == MSG_MANIFEST) begin
                           phase_in = PH_BODYO; start_in = v18[16:0];
                        end else begin
                           if (ttype == T_CPI) begin
                              put = 1'b1; put_kind = KIND_CPI;
                           end else if (ttype == T_FRAG) begin
                              put = 1'b1; put_kind = KIND_FRAG;
                           end
                           phase_in = PH_VALALG; start_in = e18[16:0];
                        end
                     end
                  end
                  PH_BODYI, PH_BODYO: begin
                     if (e18 <= {1'b0, se0_ff}) begin
                        if (ttype == T_NAME) begin
                           put = 1'b1; put_kind = KIND_NAME;
                        end else if (phase_in == PH_BODYI && ttype == T_KEYID) begin
                           put = 1'b1; put_kind = KIND_KEYID;
                        end else if (phase_in == PH_BODYI && ttype == T_OBJHASH) begin
                           put = 1'b1; put_kind = KIND_OBJHASH;
                        end else if (phase_in == PH_BODYO && ttype == T_EXPIRY) begin
                           put = 1'b1; put_kind = KIND_EXPIRY;
                        end
                        if (put) fc_in = fc_ff + 2'd1;
                     end
                     start_in = e18[16:0];
                  end
                  PH_VALALG: begin
                     if (e18 <= {2'b00, pend_ff} && ttype == ALG_CONTAINER) begin
                        phase_in = PH_VALTYPE; start_in = v18[16:0]; se1_in = e18[16:0];
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_VALTYPE: begin
                     if (e18 <= {1'b0, se1_ff} && ttype >= T_VT_LO && ttype <= T_VT_HI) begin
                        phase_in = PH_SIG; start_in = v18[16:0]; se2_in = e18[16:0];
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_SIG: begin
                     if (e18 <= {1'b0, se2_ff}) begin
                        if (ttype == T_SIG_KEYID) begin
                           put = 1'b1; put_kind = KIND_KEYID;
                        end else if (ttype == T_SIG_CERT) begin
                           put = 1'b1; put_kind = KIND_CERT;
                        end else if (ttype == T_SIG_PUBKEY) begin
                           put = 1'b1; put_kind = KIND_PUBKEY;
                        end
                     end
                     start_in = e18[16:0];
                  end
                  default: ;
               endcase
               if (put) begin
                  push.fld_valid = 1'b1;
                  push.fld.kind = put_kind;
                  push.fld.offset = v18[15:0];
                  push.fld.length = tlen;
                  push.fld.ok = 1'b1;
               end
            end
         end
      end

      // End of packet: done record, then back to the reset state.
      if (last_byte) begin
         push.done_valid = 1'b1;
         push.done.kind = KIND_DONE;
         push.done.ok = good_in;
         push.done.last = 1'b1;
         phase_in = PH_FIX; pos_in = '0; kind_in = '0; hend_in = '0; pend_in = '0;
         tl_in = '0; se0_in = '0; se1_in = '0; se2_in = '0; start_in = '0;
         fc_in = '0; good_in = 1'b0;
      end else begin
         push.fld.last = 1'b1;
         if (pos_ff != 16'hFFFF) pos_in = pos_ff + 16'd1;
      end
   end

   // Parse state registers, updated on each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIX; pos_ff <= '0; kind_ff <= '0; hend_ff <= '0; pend_ff <= '0;
         tl_ff <= '0; se0_ff <= '0; se1_ff <= '0; se2_ff <= '0; start_ff <= '0;
         fc_ff <= '0; good_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in; pos_ff <= pos_in; kind_ff <= kind_in; hend_ff <= hend_in;
         pend_ff <= pend_in; tl_ff <= tl_in; se0_ff <= se0_in; se1_ff <= se1_in;
         se2_ff <= se2_in; start_ff <= start_in; fc_ff <= fc_in; good_ff <= good_in;
      end
   end

endmodule

// ----- hw/rtl/tlvpsp_rsp_fifo.sv -----
// Four-entry result queue that takes up to two records per cycle.
`timescale 1ns / 1ps
module tlvpsp_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_en,
   input  tlvpsp_pkg::push_type push,
   output logic                 room,
   output logic                 out_valid,
   output tlvpsp_pkg::rec_type  out_rec,
   input  logic                 out_ready
);
   import tlvpsp_pkg::*;

   rec_type     mem_ff [4];
   logic [1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        pop, w0, w1;
   logic [1:0]  nw;

   assign room = cnt_ff <= 3'd2;
   assign out_valid = cnt_ff != 3'd0;
   assign out_rec = mem_ff[rd_ff];
   assign pop = out_valid && out_ready;
   assign w0 = push_en && push.fld_valid;
   assign w1 = push_en && push.done_valid;
   assign nw = {1'b0, w0} + {1'b0, w1};

   // Pointer and fill count updates.
   always_comb begin
      wr_in = wr_ff + nw;
      rd_in = rd_ff + {1'b0, pop};
      cnt_in = cnt_ff + {1'b0, nw} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   // Record storage: the field record first, the done record after it.
   always_ff @(posedge clock) begin
      if (w0) mem_ff[wr_ff] <= push.fld;
      if (w1) mem_ff[wr_ff + {1'b0, w0}] <= push.done;
   end

endmodule

// ----- hw/rtl/tlv_packet_skeleton_parser_unit.sv -----
// Top level of the streaming packet skeleton parser.
`timescale 1ns / 1ps
// Takes one packet byte per transaction and reports the offset and length of
// each recognized header, message and validation field as soon as its
// type-length header is complete, then a done record with the header status
// on the byte marked last. Each byte is parsed in the cycle it is accepted,
// so a byte can be taken every cycle; results pass through a four-entry
// queue, and a byte is accepted while at least two queue slots are free.
// A byte yields at most two results, so the output side sets the rate only
// on last bytes that also close a field or when the consumer stalls.
module tlv_packet_skeleton_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [3:0] field_kind, [19:4] field_offset,
                                    // [35:20] field_length, [36] parse_ok, rest zero
   output logic        rsp_tlast    // last_result
);
   import tlvpsp_pkg::*;

   push_type push;
   rec_type  head;
   logic     accept;

   assign accept = req_tvalid && req_tready;

   tlvpsp_core u_core (
      .clock(clock), .reset(reset), .accept(accept),
      .data_byte(req_tdata), .last_byte(req_tlast), .push(push)
   );

   tlvpsp_rsp_fifo u_fifo (
      .clock(clock), .reset(reset), .push_en(accept), .push(push),
      .room(req_tready), .out_valid(rsp_tvalid), .out_rec(head), .out_ready(rsp_tready)
   );

   // Result transaction packing.
   assign rsp_tdata = {3'b000, head.ok, head.length, head.offset, head.kind};
   assign rsp_tlast = head.last;

endmodule

// ----- hw/rtl/tlvpsp_checker.sv -----
// Port-level checker of the packet skeleton parser and its bind.
`timescale 1ns / 1ps
`include "tlv_packet_skeleton_parser_unit_assert.svh"
module tlvpsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   import tlvpsp_pkg::*;

   // The queue is empty after reset.
   `TLVPSP_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)
   // A stalled result holds.
   `TLVPSP_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, ##1 rsp_tvalid && $stable(rsp_tdata))
   // A done record closes the results of its byte.
   `TLVPSP_ASSERT(a_done_last, clock, reset, rsp_tvalid && rsp_tdata[3:0] == KIND_DONE, rsp_tlast)
   // A done record carries no offset or length.
   `TLVPSP_ASSERT(a_done_zero, clock, reset, rsp_tvalid && rsp_tdata[3:0] == KIND_DONE, rsp_tdata[35:4] == 32'd0)
endmodule

bind tlv_packet_skeleton_parser_unit tlvpsp_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);

// ----- dv/tlv_packet_skeleton_parser_checker.sv -----
// Checker that predicts and compares the parser's field and done records.
`timescale 1ns / 1ps
module tlv_packet_skeleton_parser_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count,
   output int          record_count
);
   import tlvpsp_pkg::*;

   // Walk phases of the predictor.
   typedef enum logic [3:0] {
      W_FIX, W_PERHOP, W_MSG, W_BODYI, W_BODYO, W_VALALG, W_VALTYPE, W_SIG, W_IDLE
   } walk_phase_type;

   // Expected record: {last, ok, length, offset, kind}.
   typedef logic [37:0] field_rec_type;

   field_rec_type   expected_records[$];
   field_rec_type   step_recs[$];
   logic [15:0]     pos;
   walk_phase_type  phase;
   logic [7:0]      pkt_kind;
   logic [7:0]      hdr_end;
   logic [15:0]     pkt_end;
   logic [31:0]     tl_word;
   logic [16:0]     sect_end [3];
   logic [16:0]     tl_start;
   logic [1:0]      found;
   logic            hdr_good;

   assign pending_count = expected_records.size();

   function automatic void clear_parse();
      pos = '0; phase = W_FIX; pkt_kind = '0; hdr_end = '0; pkt_end = '0; tl_word = '0;
      sect_end[0] = '0; sect_end[1] = '0; sect_end[2] = '0; tl_start = '0; found = '0;
      hdr_good = 1'b0;
   endfunction

   function automatic void add_rec(logic [3:0] k, logic [31:0] off, logic [31:0] len,
                                   logic ok);
      step_recs.push_back({1'b0, ok, len[15:0], off[15:0], k});
   endfunction

   // Skip phases whose next header cannot start.
   function automatic void skip_phases(logic [31:0] p);
      logic [31:0] s;
      logic [1:0]  lim;
      forever begin
         s = {15'd0, tl_start};
         case (phase)
            W_PERHOP: begin
               if (s + 4 < hdr_end) return;
               phase = W_MSG;
               tl_start = {9'd0, hdr_end};
            end
            W_MSG, W_VALALG: begin
               if (s + 4 < pkt_end) return;
               phase = W_IDLE;
               return;
            end
            W_BODYI, W_BODYO: begin
               lim = (phase == W_BODYI) ? 2'd3 : 2'd2;
               if (p < sect_end[0] && s < sect_end[0] && found < lim) return;
               phase = W_VALALG;
               tl_start = sect_end[0];
            end
            W_VALTYPE: begin
               if (s + 4 < sect_end[1]) return;
               phase = W_IDLE;
               return;
            end
            W_SIG: begin
               if (s + 4 < sect_end[2]) return;
               phase = W_IDLE;
               return;
            end
            default: return;
         endcase
      end
   endfunction

   // A complete type-length header has arrived.
   function automatic void take_header();
      logic [15:0] typ;
      logic [15:0] len;
      logic [31:0] v;
      logic [31:0] e;
      logic [31:0] len32;
      logic [3:0]  k;
      logic        hit;
      typ = tl_word[31:16];
      len = tl_word[15:0];
      len32 = {16'd0, len};
      v = {15'd0, tl_start} + 32'd4;
      e = v + len32;
      case (phase)
         W_PERHOP: begin
            if (e <= hdr_end && typ >= 1 && typ <= 3) add_rec(typ[3:0], v, len32, 1'b1);
            tl_start = e[16:0];
         end
         W_MSG: begin
            if (e > pkt_end) phase = W_IDLE;
            else begin
               sect_end[0] = e[16:0];
               found = 2'd0;
               if (typ == MSG_INTEREST) begin
                  phase = W_BODYI; tl_start = v[16:0];
               end else if (typ == MSG_OBJECT || typ == MSG_MANIFEST) begin
                  phase = W_BODYO; tl_start = v[16:0];
               end else begin
                  if (typ == T_CPI) add_rec(KIND_CPI, v, len32, 1'b1);
                  else if (typ == T_FRAG) add_rec(KIND_FRAG, v, len32, 1'b1);
                  phase = W_VALALG; tl_start = e[16:0];
               end
            end
         end
         W_BODYI, W_BODYO: begin
            if (e <= sect_end[0]) begin
               hit = 1'b1;
               k = KIND_NAME;
               if (typ == T_NAME) k = KIND_NAME;
               else if (phase == W_BODYI && typ == T_KEYID) k = KIND_KEYID;
               else if (phase == W_BODYI && typ == T_OBJHASH) k = KIND_OBJHASH;
               else if (phase == W_BODYO && typ == T_EXPIRY) k = KIND_EXPIRY;
               else hit = 1'b0;
               if (hit) begin
                  add_rec(k, v, len32, 1'b1);
                  found = found + 2'd1;
               end
            end
            tl_start = e[16:0];
         end
         W_VALALG: begin
            if (e <= pkt_end && typ == ALG_CONTAINER) begin
               phase = W_VALTYPE; tl_start = v[16:0]; sect_end[1] = e[16:0];
            end else phase = W_IDLE;
         end
         W_VALTYPE: begin
            if (e <= sect_end[1] && typ >= T_VT_LO && typ <= T_VT_HI) begin
               phase = W_SIG; tl_start = v[16:0]; sect_end[2] = e[16:0];
            end else phase = W_IDLE;
         end
         W_SIG: begin
            if (e <= sect_end[2]) begin
               if (typ == T_SIG_KEYID) add_rec(KIND_KEYID, v, len32, 1'b1);
               else if (typ == T_SIG_CERT) add_rec(KIND_CERT, v, len32, 1'b1);
               else if (typ == T_SIG_PUBKEY) add_rec(KIND_PUBKEY, v, len32, 1'b1);
            end
            tl_start = e[16:0];
         end
         default: ;
      endcase
   endfunction

   // Predict the records caused by one accepted byte.
   function automatic void parse_byte(logic [7:0] b, logic lst);
      logic [31:0]   p;
      field_rec_type r;
      p = {16'd0, pos};
      step_recs.delete();
      if (phase == W_FIX) begin
         if (p == 0) tl_word = {24'd0, b};
         else if (p == 1) pkt_kind = b;
         else if (p == 2) pkt_end = {b, 8'h00};
         else if (p == 3) pkt_end = {pkt_end[15:8], b};
         else if (p == 7) begin
            hdr_end = b;
            if (tl_word == 1 && (pkt_kind == PKT_INTEREST || pkt_kind == PKT_OBJECT ||
                pkt_kind == PKT_RETURN || pkt_kind == PKT_CONTROL ||
                pkt_kind == PKT_HOPHASH) && hdr_end >= 8 && pkt_end >= hdr_end) begin
               hdr_good = 1'b1;
               if (pkt_kind == PKT_INTEREST) add_rec(KIND_HOPLIMIT, 32'd4, 32'd1, 1'b1);
               phase = W_PERHOP;
               tl_start = 17'd8;
            end else phase = W_IDLE;
            tl_word = '0;
         end
      end else begin
         skip_phases(p);
         if (phase >= W_PERHOP && phase <= W_SIG && p >= tl_start && p <= tl_start + 3) begin
            tl_word = {tl_word[23:0], b};
            if (p == tl_start + 3) take_header();
         end
      end
      if (lst) begin
         add_rec(KIND_DONE, 32'd0, 32'd0, hdr_good);
         clear_parse();
      end else if (pos != 16'hFFFF) pos = pos + 16'd1;
      for (int i = 0; i < step_recs.size(); i++) begin
         r = step_recs[i];
         if (i == step_recs.size() - 1) r[37] = 1'b1;
         expected_records.push_back(r);
      end
   endfunction

   // Predict on input transactions, compare on output transactions.
   always @(posedge clock) begin
      field_rec_type exp_r;
      field_rec_type got_r;
      if (reset) begin
         clear_parse();
         expected_records.delete();
         fail_count <= 0;
         record_count <= 0;
      end else begin
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            record_count <= record_count + 1;
            got_r = {rsp_tlast, rsp_tdata[36:0]};
            if (expected_records.size() == 0) begin
               if (fail_count < 10) $display("unexpected record %h", got_r);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_records.pop_front();
               if (got_r !== exp_r || rsp_tdata[39:37] !== 3'b000) begin
                  if (fail_count < 10)
                     $display("mismatch: kind %0d/%0d off %0d/%0d len %0d/%0d ok %b/%b last %b/%b",
                        exp_r[3:0], got_r[3:0], exp_r[19:4], got_r[19:4], exp_r[35:20],
                        got_r[35:20], exp_r[36], got_r[36], exp_r[37], got_r[37]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- dv/tb_top.sv -----
// Testbench top: stimulus, clock, reset and verdict for the packet skeleton parser.
`timescale 1ns / 1ps
module tb_top;
   import tlvpsp_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count;
   int          pending_count;
   int          record_count;
   int          bytes_sent = 0;
   int          packets_sent = 0;
   bit          hold_rsp = 1'b0;
   logic [7:0]  pkt_bytes[$];

   always #1 clock = ~clock;

   tlv_packet_skeleton_parser_unit dut (.*);

   tlv_packet_skeleton_parser_checker checker_i (.*);

   // Consumer: random stall before each transaction, plus one long hold-off.
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = $urandom_range(0, 3);
         if ($urandom_range(0, 5) == 0) gap = 0;
         if (gap > 0 || hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Hold the consumer off for a long stretch while bytes keep coming.
   initial begin
      wait (packets_sent == 20);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp = 1'b0;
   end

   task automatic send_byte(logic [7:0] b, logic lst, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet(bit no_gap);
      for (int i = 0; i < pkt_bytes.size(); i++)
         send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, no_gap);
      packets_sent++;
   endtask

   task automatic push_tl(logic [15:0] t, logic [15:0] l);
      pkt_bytes.push_back(t[15:8]); pkt_bytes.push_back(t[7:0]);
      pkt_bytes.push_back(l[15:8]); pkt_bytes.push_back(l[7:0]);
   endtask

   task automatic push_fill(int n);
      repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Build a mostly well-formed packet with random content.
   task automatic build_packet();
      logic [7:0]  kinds[5];
      logic [7:0]  kind;
      logic [15:0] msg_t;
      logic [15:0] tl_t;
      int          hops, hlen, blen, vlen, slen, n, sz, plen;
      int          hop_base, body_start;
      kinds = '{PKT_INTEREST, PKT_OBJECT, PKT_RETURN, PKT_CONTROL, PKT_HOPHASH};
      pkt_bytes.delete();
      kind = kinds[$urandom_range(0, 4)];
      hops = $urandom_range(0, 2);
      hop_base = 8;
      pkt_bytes = '{8'h01, kind, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      for (int i = 0; i < hops; i++) begin
         sz = $urandom_range(0, 4);
         push_tl(16'($urandom_range(0, 4)), 16'(sz));
         push_fill(sz);
      end
      hlen = pkt_bytes.size();
      // Message container.
      case ($urandom_range(0, 4))
         0: msg_t = MSG_INTEREST;
         1: msg_t = MSG_OBJECT;
         2: msg_t = MSG_MANIFEST;
         3: msg_t = T_CPI;
         default: msg_t = T_FRAG;
      endcase
      body_start = pkt_bytes.size();
      push_tl(msg_t, 16'd0);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         sz = $urandom_range(0, 5);
         case ($urandom_range(0, 4))
            0: tl_t = T_NAME;
            1: tl_t = T_KEYID;
            2: tl_t = T_OBJHASH;
            3: tl_t = T_EXPIRY;
            default: tl_t = 16'($urandom_range(0, 16'hFFFF));
         endcase
         push_tl(tl_t, 16'(sz));
         push_fill(sz);
      end
      if ($urandom_range(0, 7) == 0) push_fill($urandom_range(1, 3));
      blen = pkt_bytes.size() - body_start - 4;
      if ($urandom_range(0, 9) == 0) blen = blen + $urandom_range(1, 6);
      pkt_bytes[body_start + 2] = 8'(blen >> 8);
      pkt_bytes[body_start + 3] = 8'(blen);
      // Validation algorithm with one type and a few parameters.
      if ($urandom_range(0, 3) != 0) begin
         push_tl(ALG_CONTAINER, 16'd0);
         vlen = pkt_bytes.size();
         push_tl(16'($urandom_range(5, 9)), 16'd0);
         slen = pkt_bytes.size();
         n = $urandom_range(0, 3);
         for (int i = 0; i < n; i++) begin
            sz = $urandom_range(0, 4);
            case ($urandom_range(0, 3))
               0: tl_t = T_SIG_KEYID;
               1: tl_t = T_SIG_CERT;
               2: tl_t = T_SIG_PUBKEY;
               default: tl_t = 16'($urandom_range(0, 16));
            endcase
            push_tl(tl_t, 16'(sz));
            push_fill(sz);
         end
         sz = pkt_bytes.size() - slen;
         pkt_bytes[slen - 2] = 8'(sz >> 8); pkt_bytes[slen - 1] = 8'(sz);
         sz = pkt_bytes.size() - vlen;
         pkt_bytes[vlen - 2] = 8'(sz >> 8); pkt_bytes[vlen - 1] = 8'(sz);
      end
      plen = pkt_bytes.size();
      if ($urandom_range(0, 9) == 0) plen = plen - $urandom_range(0, 6);
      if ($urandom_range(0, 9) == 0) push_fill($urandom_range(1, 4));
      pkt_bytes[2] = 8'(plen >> 8);
      pkt_bytes[3] = 8'(plen);
      pkt_bytes[7] = 8'(hlen);
      // Noise: corrupt a byte now and then, or cut the packet short.
      if ($urandom_range(0, 11) == 0)
         pkt_bytes[$urandom_range(0, pkt_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0)
         while (pkt_bytes.size() > 1 && $urandom_range(0, 3) != 0) void'(pkt_bytes.pop_back());
   endtask

   // Stimulus: directed cases, random packets, then drain.
   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Interest with hop limit, per-hop lifetime, name, and signature cert.
      pkt_bytes = '{8'h01, 8'h00, 8'h00, 8'h26, 8'hFF, 8'h00, 8'h00, 8'h0E,
                    8'h00, 8'h01, 8'h00, 8'h02, 8'hAA, 8'h55,
                    8'h00, 8'h01, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h04,
                    8'h00, 8'hFF, 8'h80, 8'h01,
                    8'h00, 8'h03, 8'h00, 8'h08, 8'h00, 8'h06, 8'h00, 8'h04,
                    8'h00, 8'h0C, 8'h00, 8'h00};
      send_packet(1);
      // Bad version, then a short packet, then a one-byte packet.
      pkt_bytes = '{8'hFE, 8'hA4, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h08, 8'h7F};
      send_packet(0);
      pkt_bytes = '{8'h01, 8'h00, 8'h00};
      send_packet(0);
      pkt_bytes = '{8'h00};
      send_packet(0);
      // Header length above packet length.
      pkt_bytes = '{8'h01, 8'h01, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h09};
      send_packet(0);
      while (bytes_sent < 1500) begin
         build_packet();
         send_packet($urandom_range(0, 3) == 0);
      end
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("tb_top: %0d bytes in %0d packets, %0d records checked",
               bytes_sent, packets_sent, record_count);
      if (fail_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Overall time limit.
   initial begin
      #2000000;
      $display("tb_top: errors");
      $finish;
   end
endmodule
